@@ rtl/dtmfgen_pkg.sv @@
// Shared types, constants, DTMF frequency table and microcode ROM for the tone generator.
`default_nettype none

package dtmfgen_pkg;

	// Datapath operations, one per microcode step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_FRED,
		OP_DBL,
		OP_ADDB,
		OP_RECIP,
		OP_QUOT,
		OP_PHASE,
		OP_SQ,
		OP_Z2,
		OP_P2,
		OP_P3,
		OP_SIN,
		OP_MIX,
		OP_EMIT
	} op_t;

	// Jump conditions of the sequencer.
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_ACCEPT,
		JC_CNT_NZ,
		JC_NO_WORK,
		JC_OUT_FREE
	} jc_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic adv;
	} lane_ctrl_t;

	typedef struct packed {
		logic accept;
		logic tick;
		logic no_work;
		logic out_free;
	} seq_flags_t;

	localparam logic       CMD_LOAD     = 1'b0;
	localparam logic       CMD_TICK     = 1'b1;
	localparam logic [1:0] MODE_SILENCE = 2'd0;
	localparam logic [1:0] MODE_PAIR    = 2'd1;
	localparam logic [1:0] MODE_KEY     = 2'd2;
	localparam logic [3:0] KEY_MAX      = 4'd9;

	localparam logic [14:0] VOLUME_RESET = 15'd6554;

	// Polynomial sine coefficients and the quarter-turn phase.
	localparam logic [12:0] SIN_C1  = 13'd4926;
	localparam logic [15:0] SIN_C2  = 16'd42334;
	localparam logic [16:0] SIN_C3  = 17'd102944;
	localparam logic [14:0] QUARTER = 15'd16384;

	// Program entry points.
	localparam step_t ST_WAIT = 4'd0;
	localparam step_t ST_LOAD = 4'd1;
	localparam step_t ST_DBL  = 4'd2;
	localparam step_t ST_TICK = 4'd5;
	localparam step_t ST_EMIT = 4'd14;

	function automatic logic [11:0] dtmf_low(input logic [3:0] key);
		logic [11:0] f;
		unique case (key)
			4'd0: f = 12'd941;
			4'd1, 4'd2, 4'd3: f = 12'd697;
			4'd4, 4'd5, 4'd6: f = 12'd770;
			4'd7, 4'd8, 4'd9: f = 12'd852;
			default: f = 12'd0;
		endcase
		return f;
	endfunction

	function automatic logic [11:0] dtmf_high(input logic [3:0] key);
		logic [11:0] f;
		unique case (key)
			4'd1, 4'd4, 4'd7: f = 12'd1209;
			4'd0, 4'd2, 4'd5, 4'd8: f = 12'd1336;
			4'd3, 4'd6, 4'd9: f = 12'd1477;
			default: f = 12'd0;
		endcase
		return f;
	endfunction

	// Microcode ROM. Steps 1 to 4 handle a load, steps 5 to 14 a tick.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			4'd0:  w = '{op: OP_WAIT,  jc: JC_ACCEPT,   target: ST_TICK};
			4'd1:  w = '{op: OP_FRED,  jc: JC_NEXT,     target: ST_WAIT};
			4'd2:  w = '{op: OP_DBL,   jc: JC_NEXT,     target: ST_WAIT};
			4'd3:  w = '{op: OP_ADDB,  jc: JC_CNT_NZ,   target: ST_DBL};
			4'd4:  w = '{op: OP_NOP,   jc: JC_ALWAYS,   target: ST_WAIT};
			4'd5:  w = '{op: OP_RECIP, jc: JC_NO_WORK,  target: ST_EMIT};
			4'd6:  w = '{op: OP_QUOT,  jc: JC_NEXT,     target: ST_WAIT};
			4'd7:  w = '{op: OP_PHASE, jc: JC_NEXT,     target: ST_WAIT};
			4'd8:  w = '{op: OP_SQ,    jc: JC_NEXT,     target: ST_WAIT};
			4'd9:  w = '{op: OP_Z2,    jc: JC_NEXT,     target: ST_WAIT};
			4'd10: w = '{op: OP_P2,    jc: JC_NEXT,     target: ST_WAIT};
			4'd11: w = '{op: OP_P3,    jc: JC_NEXT,     target: ST_WAIT};
			4'd12: w = '{op: OP_SIN,   jc: JC_NEXT,     target: ST_WAIT};
			4'd13: w = '{op: OP_MIX,   jc: JC_NEXT,     target: ST_WAIT};
			4'd14: w = '{op: OP_EMIT,  jc: JC_OUT_FREE, target: ST_WAIT};
			default: w = '{op: OP_NOP, jc: JC_ALWAYS,   target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dtmfgen_useq.sv @@
// Microcode sequencer: step counter, ROM lookup, conditional jumps and loop counter.
`default_nettype none

module dtmfgen_useq #(
	parameter int POS_W = 13
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  dtmfgen_pkg::seq_flags_t  flags,
	output dtmfgen_pkg::op_t         op,
	output logic [$clog2(POS_W)-1:0] cnt
);
	import dtmfgen_pkg::*;

	localparam int CW = $clog2(POS_W);

	step_t           pc_q;
	step_t           pc_d;
	uword_t          uw;
	logic [CW-1:0]   cnt_q;

	assign uw  = ucode(pc_q);
	assign op  = uw.op;
	assign cnt = cnt_q;

	always_comb begin
		unique case (uw.jc)
			JC_NEXT:     pc_d = pc_q + 4'd1;
			JC_ALWAYS:   pc_d = uw.target;
			JC_ACCEPT: begin
				if (!flags.accept)
					pc_d = pc_q;
				else if (flags.tick)
					pc_d = uw.target;
				else
					pc_d = pc_q + 4'd1;
			end
			JC_CNT_NZ:   pc_d = (cnt_q != '0) ? uw.target : pc_q + 4'd1;
			JC_NO_WORK:  pc_d = flags.no_work ? uw.target : pc_q + 4'd1;
			JC_OUT_FREE: pc_d = flags.out_free ? uw.target : pc_q;
			default:     pc_d = ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= ST_WAIT;
			cnt_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (uw.op == OP_FRED)
				cnt_q <= CW'(POS_W - 1);
			else if (uw.op == OP_ADDB)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/dtmfgen_lane.sv @@
// One tone lane: phase residue, reciprocal phase scaling and polynomial sine.
`default_nettype none

module dtmfgen_lane #(
	parameter int SAMPLE_RATE = 8000
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  dtmfgen_pkg::lane_ctrl_t  ctrl,
	input  wire  [11:0]              freq_in,
	input  wire                      pos_bit,
	output logic signed [15:0]       sine
);
	import dtmfgen_pkg::*;

	localparam int PW = $clog2(SAMPLE_RATE);
	localparam int AW = PW + 2;
	localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(SAMPLE_RATE);
	localparam int MW = $clog2(RECIP_FULL + 64'd1);
	localparam int PRODW = (PW + MW > 34) ? (PW + MW) : 34;
	localparam logic [PRODW-1:0] RECIP = PRODW'(RECIP_FULL);
	localparam logic [PRODW-1:0] SR_P  = PRODW'(SAMPLE_RATE);
	localparam logic [AW-1:0]    SR_A  = AW'(SAMPLE_RATE);
	localparam logic [PW+16:0]   SR_E  = (PW + 17)'(SAMPLE_RATE);

	// Reduce a value below twice the sample rate into the residue range.
	function automatic logic [PW-1:0] fold_sr(input logic [AW-1:0] v);
		logic [AW-1:0] d;
		d = v - SR_A;
		return (v >= SR_A) ? d[PW-1:0] : v[PW-1:0];
	endfunction

	logic [11:0]        f_q;
	logic [PW-1:0]      rem_q;
	logic [PRODW-1:0]   prod_q;
	logic [15:0]        q_q;
	logic [1:0]         quad_q;
	logic [16:0]        z_q;
	logic [16:0]        z2_q;
	logic signed [15:0] sine_q;

	logic [AW-1:0]      rem_dbl;
	logic [AW-1:0]      rem_add;
	logic [AW-1:0]      f_diff;
	logic [11:0]        f_red;
	logic [PW+16:0]     num;
	logic [PW+16:0]     err;
	logic [15:0]        phase;
	logic [14:0]        xm;
	logic [16:0]        z_next;
	logic [15:0]        t2;
	logic [16:0]        t4;
	logic [15:0]        rh;
	logic [14:0]        mag;
	logic signed [15:0] sine_next;

	assign rem_dbl = {1'b0, rem_q, 1'b0};
	assign rem_add = AW'(rem_q) + AW'(f_q);
	assign f_diff  = AW'(f_q) - SR_A;
	assign f_red   = (AW'(f_q) >= SR_A) ? f_diff[11:0] : f_q;

	// The reciprocal quotient is at most one short; the remainder decides the fix.
	assign num   = {1'b0, rem_q, 16'h0000};
	assign err   = num - prod_q[PW+16:0];
	assign phase = q_q + {15'd0, (err >= SR_E)};
	assign xm    = phase[14] ? (QUARTER - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
	assign z_next = {xm, 2'b00};

	assign t2  = SIN_C2 - {3'b000, prod_q[28:16]};
	assign t4  = SIN_C3 - {1'b0, prod_q[31:16]};
	assign rh  = prod_q[32:17];
	assign mag = rh[15] ? 15'h7FFF : rh[14:0];
	assign sine_next = quad_q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	assign sine = sine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q   <= '0;
			rem_q <= '0;
		end else begin
			if (ctrl.load)
				f_q <= freq_in;
			else if (ctrl.op == OP_FRED)
				f_q <= f_red;

			if (ctrl.op == OP_FRED)
				rem_q <= '0;
			else if (ctrl.op == OP_DBL)
				rem_q <= fold_sr(rem_dbl);
			else if ((ctrl.op == OP_ADDB && pos_bit) || ctrl.adv)
				rem_q <= fold_sr(rem_add);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_RECIP: prod_q <= PRODW'(rem_q) * RECIP;
			OP_QUOT: begin
				q_q    <= prod_q[31:16];
				prod_q <= PRODW'(prod_q[31:16]) * SR_P;
			end
			OP_PHASE: begin
				quad_q <= phase[15:14];
				z_q    <= z_next;
			end
			OP_SQ: prod_q <= PRODW'(z_q) * PRODW'(z_q);
			OP_Z2: begin
				z2_q   <= prod_q[32:16];
				prod_q <= PRODW'(prod_q[32:16]) * PRODW'(SIN_C1);
			end
			OP_P2:  prod_q <= PRODW'(t2) * PRODW'(z2_q);
			OP_P3:  prod_q <= PRODW'(t4) * PRODW'(z_q);
			OP_SIN: sine_q <= sine_next;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/dtmf_dual_tone_generator_core.sv @@
// Top level of the dual-tone and DTMF segment generator.
// A tone tick runs the full sine program; no new item is taken until its result is registered.
// A silent or idle tick skips the sine steps and registers a silent result.
// A load gives no result; a doubling loop over the position bits rebuilds the phase residues
// of the new frequencies.
// arst_n clears the sequencer, the segment state and the output valid flag; volume resets to 0.2.
`default_nettype none

module dtmf_dual_tone_generator_core #(
	parameter int SAMPLE_RATE = 8000
) (
	input  wire                clk,
	input  wire                arst_n,
	// Input item channel.
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                cmd,
	input  wire  [1:0]         tone_mode,
	input  wire  [3:0]         key_digit,
	input  wire  [11:0]        first_freq,
	input  wire  [11:0]        second_freq,
	input  wire  [12:0]        duration_ms,
	// Result item channel.
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [15:0] sample,
	output logic               segment_last,
	output logic               idle,
	// Volume register write channel.
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [14:0]        volume
);
	import dtmfgen_pkg::*;

	// Position width, samples per millisecond and the width of the raw segment length.
	localparam int PW   = $clog2(SAMPLE_RATE);
	localparam int CW   = $clog2(PW);
	localparam int SPM  = SAMPLE_RATE / 1000;
	localparam int LENW = 14 + $clog2(SPM + 1);

	// Segment state.
	logic [PW-1:0]      pos_q;
	logic [15:0]        remaining_q;
	logic               tone_q;
	logic [14:0]        volume_q;

	// Mixer and output register.
	logic signed [32:0] mix_q;
	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               last_q;
	logic               idle_q;

	op_t                seq_op;
	logic [CW-1:0]      cnt;
	seq_flags_t         flags;
	lane_ctrl_t         lane_ctrl;

	logic               in_acc;
	logic               load_acc;
	logic               out_free;
	logic               emit_fire;
	logic               adv;

	logic               tone_d;
	logic [11:0]        f1_d;
	logic [11:0]        f2_d;
	logic [LENW-1:0]    len;
	logic [15:0]        len_sat;

	logic signed [15:0] sine1;
	logic signed [15:0] sine2;
	logic signed [16:0] sum;
	logic signed [32:0] rnd_full;
	logic [17:0]        rnd;
	logic signed [15:0] rnd_sat;

	// The sequencer only sits at its wait step when it can take a new item.
	assign in_stall  = (seq_op != OP_WAIT);
	assign in_acc    = in_valid && !in_stall;
	assign load_acc  = in_acc && (cmd == CMD_LOAD);
	assign cfg_ready = 1'b1;

	// The output register is free when it is empty or being emptied this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = (seq_op == OP_EMIT) && out_free;
	// Position and phases advance only on a sample that belongs to a segment.
	assign adv       = emit_fire && (remaining_q != 16'd0);

	assign flags.accept   = in_acc;
	assign flags.tick     = (cmd == CMD_TICK);
	assign flags.no_work  = (remaining_q == 16'd0) || !tone_q;
	assign flags.out_free = out_free;

	assign lane_ctrl.op   = seq_op;
	assign lane_ctrl.load = load_acc;
	assign lane_ctrl.adv  = adv;

	dtmfgen_useq #(
		.POS_W (PW)
	) u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (seq_op),
		.cnt    (cnt)
	);

	// The load loop walks the position from its top bit down to bit zero.
	dtmfgen_lane #(
		.SAMPLE_RATE (SAMPLE_RATE)
	) u_lane1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lane_ctrl),
		.freq_in (f1_d),
		.pos_bit (pos_q[cnt]),
		.sine    (sine1)
	);

	dtmfgen_lane #(
		.SAMPLE_RATE (SAMPLE_RATE)
	) u_lane2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lane_ctrl),
		.freq_in (f2_d),
		.pos_bit (pos_q[cnt]),
		.sine    (sine2)
	);

	// Decode of a load item. Mode three and a key above nine both fall back to silence.
	always_comb begin
		tone_d = 1'b0;
		f1_d   = 12'd0;
		f2_d   = 12'd0;
		if (tone_mode == MODE_PAIR) begin
			tone_d = 1'b1;
			f1_d   = first_freq;
			f2_d   = second_freq;
		end else if (tone_mode == MODE_KEY && key_digit <= KEY_MAX) begin
			tone_d = 1'b1;
			f1_d   = dtmf_low(key_digit);
			f2_d   = dtmf_high(key_digit);
		end
	end

	// Segment length in samples, saturated to the counter's range.
	assign len     = LENW'(duration_ms) * LENW'(SPM);
	assign len_sat = (|len[LENW-1:16]) ? 16'hFFFF : len[15:0];

	// Mixing: the two sines are summed, scaled by the volume, rounded half up and saturated.
	assign sum      = {sine1[15], sine1} + {sine2[15], sine2};
	assign rnd_full = mix_q + 33'sd16384;
	assign rnd      = rnd_full[32:15];

	always_comb begin
		if (rnd[17:15] == 3'b000 || rnd[17:15] == 3'b111)
			rnd_sat = $signed(rnd[15:0]);
		else if (rnd[17])
			rnd_sat = 16'sh8000;
		else
			rnd_sat = 16'sh7FFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			remaining_q <= '0;
			tone_q      <= 1'b0;
			volume_q    <= VOLUME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				volume_q <= volume;

			if (load_acc) begin
				remaining_q <= len_sat;
				tone_q      <= tone_d;
			end else if (adv) begin
				remaining_q <= remaining_q - 16'd1;
			end

			// The position wraps at the sample rate so it never leaves one second.
			if (adv) begin
				if (pos_q == PW'(SAMPLE_RATE - 1))
					pos_q <= '0;
				else
					pos_q <= pos_q + PW'(1);
			end

			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (seq_op == OP_MIX)
			mix_q <= $signed({1'b0, volume_q}) * sum;

		if (emit_fire) begin
			idle_q   <= (remaining_q == 16'd0);
			last_q   <= (remaining_q == 16'd1);
			sample_q <= (remaining_q != 16'd0 && tone_q) ? rnd_sat : 16'sd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = sample_q;
	assign segment_last = last_q;
	assign idle         = idle_q;

endmodule

`default_nettype wire

@@ rtl/dtmfgen_checker.sv @@
// Port-level checker for the tone generator and its bind to the top level.
`default_nettype none

module dtmfgen_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] sample,
	input wire        segment_last,
	input wire        idle
);

	// Every item keeps the block busy for at least the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// No result can appear in the cycle right after an item is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared too early");

	// An idle result is silent and never closes a segment.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && idle) |-> (sample == 16'h0000 && !segment_last))
		else $error("idle result carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sample) && $stable(idle)
			&& $stable(segment_last)))
		else $error("stalled result changed");

endmodule

bind dtmf_dual_tone_generator_core dtmfgen_checker u_dtmfgen_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample       (sample),
	.segment_last (segment_last),
	.idle         (idle)
);

`default_nettype wire
